// File: src/tcf_pkg.sv
// Shared types and constants of the tilt complementary filter.
// Request payload structs, sequencer states and the CORDIC arctangent table.
// No dependencies.
package tcf_pkg;

    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 21;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic               over_limit;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ITER,
        ST_ACC,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_RND,
        ST_FIN
    } t_state;

    // atan(2^-i) in 1/32768 degree, rounded
    function automatic logic [ATAN_W-1:0] atan_q15(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 21'd1474560;
            5'd1:    v = 21'd870484;
            5'd2:    v = 21'd459940;
            5'd3:    v = 21'd233473;
            5'd4:    v = 21'd117189;
            5'd5:    v = 21'd58652;
            5'd6:    v = 21'd29333;
            5'd7:    v = 21'd14667;
            5'd8:    v = 21'd7334;
            5'd9:    v = 21'd3667;
            5'd10:   v = 21'd1833;
            5'd11:   v = 21'd917;
            5'd12:   v = 21'd458;
            5'd13:   v = 21'd229;
            5'd14:   v = 21'd115;
            5'd15:   v = 21'd57;
            5'd16:   v = 21'd29;
            5'd17:   v = 21'd14;
            5'd18:   v = 21'd7;
            5'd19:   v = 21'd4;
            5'd20:   v = 21'd2;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/tilt_complementary_filter.sv
// Tilt complementary filter top level: CORDIC pitch, gyro integration, blend.
// Depends on tcf_pkg for payload structs, sequencer states and the atan table.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one inertial
//   sample: accel_x, accel_z, gyro_y. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns the fused pitch and the over-limit flag,
//   one result per request, in order.
//   After preparation, one request runs CORDIC_STEPS rotation steps on the
//   shared CORDIC add/shift unit and three products on the shared 18x18
//   multiplier, then rounding and output load; o_in_stall stays high for that
//   whole time, so a new request is taken only once the sequencer is idle.
//   Both zero accelerometer samples skip the CORDIC loop.
//   The result sits in an output register; a new request is taken while it
//   waits. A stalled result holds; the sequencer holds in its last step until
//   the output register is free.
//   Reset (synchronous, active low) clears the stored angle, empties the
//   output register and loads the default register values.
//   APB registers: 0x0 accel_offset, 0x4 gyro_offset, 0x8 alpha_weight,
//   0xC tilt_limit. Write only while no request is in flight.
module tilt_complementary_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  tcf_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output tcf_pkg::t_out o_out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tcf_pkg::*;

    localparam logic [1:0] REG_ACCEL_OFS = 2'd0;
    localparam logic [1:0] REG_GYRO_OFS  = 2'd1;
    localparam logic [1:0] REG_ALPHA     = 2'd2;
    localparam logic [1:0] REG_LIMIT     = 2'd3;

    localparam logic [ATAN_IDX_W-1:0] LastStep = ATAN_IDX_W'(CORDIC_STEPS - 1);
    localparam logic signed [24:0] HalfTurn = 25'sd5898240;

    t_state r_state, n_state;
    logic [ATAN_IDX_W-1:0] r_step, n_step;
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;
    logic signed [11:0] r_accel_ofs, n_accel_ofs;
    logic signed [11:0] r_gyro_ofs, n_gyro_ofs;
    logic [15:0] r_alpha, n_alpha;
    logic [14:0] r_limit, n_limit;
    logic signed [15:0] r_fused, n_fused;

    t_in r_in, n_in;
    logic signed [16:0] r_gy, n_gy;
    logic signed [33:0] r_xs, n_xs;
    logic signed [33:0] r_ys, n_ys;
    logic signed [24:0] r_z, n_z;
    logic signed [17:0] r_accel, n_accel;
    logic signed [35:0] r_prod, n_prod;
    logic signed [51:0] r_blend, n_blend;
    logic signed [15:0] r_ang, n_ang;

    logic cfg_wr;
    logic signed [33:0] x0, y0, dx, dy;
    logic signed [24:0] tab, z_rnd;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;
    logic [16:0] weight;
    logic signed [51:0] p_ext, rsum;
    logic signed [19:0] q;
    logic [16:0] mag;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[3:2])
            REG_ACCEL_OFS: prdata = {20'd0, r_accel_ofs};
            REG_GYRO_OFS:  prdata = {20'd0, r_gyro_ofs};
            REG_ALPHA:     prdata = {16'd0, r_alpha};
            REG_LIMIT:     prdata = {17'd0, r_limit};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        weight = 17'(17'h10000 - {1'b0, r_alpha});
        case (r_state)
            ST_MUL0: begin
                mul_a = {2'b00, r_alpha};
                mul_b = r_accel;
            end
            ST_MUL1: begin
                mul_a = {1'b0, weight};
                mul_b = {{2{r_fused[15]}}, r_fused};
            end
            default: begin
                mul_a = {1'b0, weight};
                mul_b = {r_gy[16], r_gy};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_accel_ofs = r_accel_ofs;
        n_gyro_ofs  = r_gyro_ofs;
        n_alpha     = r_alpha;
        n_limit     = r_limit;
        n_fused     = r_fused;
        n_in        = r_in;
        n_gy        = r_gy;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_z         = r_z;
        n_accel     = r_accel;
        n_prod      = r_prod;
        n_blend     = r_blend;
        n_ang       = r_ang;

        y0    = 34'(r_in.accel_x);
        x0    = 34'(r_in.accel_z);
        dx    = r_ys >>> r_step;
        dy    = r_xs >>> r_step;
        tab   = 25'(atan_q15(r_step));
        z_rnd = r_z + 25'sd128;
        p_ext = 52'(r_prod);
        rsum  = r_blend + 52'sh0_0000_8000_0000;
        q     = rsum[51:32];
        mag   = r_ang[15] ? 17'(-{r_ang[15], r_ang}) : {1'b0, r_ang};

        if (cfg_wr) begin
            case (paddr[3:2])
                REG_ACCEL_OFS: n_accel_ofs = pwdata[11:0];
                REG_GYRO_OFS:  n_gyro_ofs  = pwdata[11:0];
                REG_ALPHA:     n_alpha     = pwdata[15:0];
                REG_LIMIT:     n_limit     = pwdata[14:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_gy    = 17'(i_in_data.gyro_y) + 17'(r_gyro_ofs);
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_step = '0;
                if (r_in.accel_x == 16'sd0 && r_in.accel_z == 16'sd0) begin
                    n_z     = '0;
                    n_state = ST_ACC;
                end else if (r_in.accel_z < 16'sd0) begin
                    n_z     = (r_in.accel_x >= 16'sd0) ? HalfTurn : -HalfTurn;
                    n_xs    = (-x0) <<< 12;
                    n_ys    = (-y0) <<< 12;
                    n_state = ST_ITER;
                end else begin
                    n_z     = '0;
                    n_xs    = x0 <<< 12;
                    n_ys    = y0 <<< 12;
                    n_state = ST_ITER;
                end
            end
            ST_ITER: begin
                if (r_ys >= 34'sd0) begin
                    n_xs = r_xs + dx;
                    n_ys = r_ys - dy;
                    n_z  = r_z + tab;
                end else begin
                    n_xs = r_xs - dx;
                    n_ys = r_ys + dy;
                    n_z  = r_z - tab;
                end
                if (r_step == LastStep) begin
                    n_state = ST_ACC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ACC: begin
                n_accel = 18'(r_accel_ofs) - {z_rnd[24], z_rnd[24:8]};
                n_state = ST_MUL0;
            end
            ST_MUL0: begin
                n_prod  = mul_p;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_blend = p_ext <<< 16;
                n_prod  = mul_p;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_blend = r_blend + (p_ext <<< 16);
                n_prod  = mul_p;
                n_state = ST_MUL3;
            end
            ST_MUL3: begin
                n_blend = r_blend + (p_ext <<< 12) + (p_ext <<< 10);
                n_state = ST_RND;
            end
            ST_RND: begin
                if (q > 20'sd32767) begin
                    n_ang = 16'sh7FFF;
                end else if (q < -20'sd32768) begin
                    n_ang = 16'sh8000;
                end else begin
                    n_ang = q[15:0];
                end
                n_fused = n_ang;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.tilt_angle = r_ang;
                    n_out.over_limit = (mag >= {2'b00, r_limit});
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_accel_ofs <= 12'sd192;
            r_gyro_ofs  <= 12'sd30;
            r_alpha     <= 16'd655;
            r_limit     <= 15'd6400;
            r_fused     <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_accel_ofs <= n_accel_ofs;
            r_gyro_ofs  <= n_gyro_ofs;
            r_alpha     <= n_alpha;
            r_limit     <= n_limit;
            r_fused     <= n_fused;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_in    <= n_in;
        r_gy    <= n_gy;
        r_xs    <= n_xs;
        r_ys    <= n_ys;
        r_z     <= n_z;
        r_accel <= n_accel;
        r_prod  <= n_prod;
        r_blend <= n_blend;
        r_ang   <= n_ang;
    end

endmodule

// File: src/tcf_checker.sv
// Port-level checker for the tilt complementary filter, bound to the top level.
// Depends on tcf_pkg for the payload structs.
module tcf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input tcf_pkg::t_out o_out_data
);
    import tcf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while not busy afterwards");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in flight");

    a_full_scale_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.tilt_angle == 16'sh8000 |-> o_out_data.over_limit)
        else $error("negative full scale angle not flagged");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tilt_complementary_filter: directed table, then phased random samples.
// Carries its own CORDIC pitch, gyro integration and blend prediction; needs tcf_pkg and the RTL.
module tb;
    import tcf_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE       = 8;

    typedef enum int {
        REG_ACCEL_OFFSET = 0,
        REG_GYRO_OFFSET  = 1,
        REG_ALPHA_WEIGHT = 2,
        REG_TILT_LIMIT   = 3
    } t_reg;

    typedef enum int {GYRO_SPREAD, GYRO_CLIMB, GYRO_FALL} t_gyro_bias;
    typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY} t_sink_mode;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] az;
        logic signed [15:0] gy;
        logic               typed;
        logic signed [15:0] want_angle;
        logic               want_flag;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic signed [11:0] cfg_accel_offset = 12'sd192;
    logic signed [11:0] cfg_gyro_offset  = 12'sd30;
    logic [15:0]        cfg_alpha        = 16'd655;
    logic [14:0]        cfg_tilt_limit   = 15'd6400;
    logic signed [15:0] pitch_state      = '0;

    t_out       pitch_expected [$];
    t_row       directed_rows [$];
    int         mismatches       = 0;
    int         samples_sent     = 0;
    int         results_seen     = 0;
    int         settings_written = 0;
    int         burst_left       = 0;
    int         burst_max        = 8;
    int         gap_max          = 20;
    t_sink_mode sink_mode        = SINK_LIGHT;
    int         sink_left        = 0;
    logic       sink_hold        = 1'b0;

    tilt_complementary_filter #(.CORDIC_STEPS(CORDIC_STEPS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint atan_step(input int i);
        case (i)
            0:       return 1474560;
            1:       return 870484;
            2:       return 459940;
            3:       return 233473;
            4:       return 117189;
            5:       return 58652;
            6:       return 29333;
            7:       return 14667;
            8:       return 7334;
            9:       return 3667;
            10:      return 1833;
            11:      return 917;
            12:      return 458;
            13:      return 229;
            14:      return 115;
            15:      return 57;
            16:      return 29;
            17:      return 14;
            18:      return 7;
            19:      return 4;
            20:      return 2;
            21:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic t_out predict_pitch(input t_in s);
        longint y, x, xs, ys, dx, dy, zsum, acc, gyro_q16, blend, mag;
        int     i;
        t_out   r;
        y    = s.accel_x;
        x    = s.accel_z;
        zsum = 0;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                zsum = (y >= 0) ? 180 * 32768 : -180 * 32768;
                x    = -x;
                y    = -y;
            end
            xs = x * 4096;
            ys = y * 4096;
            for (i = 0; i < CORDIC_STEPS; i++) begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys >= 0) begin
                    xs   = xs + dx;
                    ys   = ys - dy;
                    zsum = zsum + atan_step(i);
                end else begin
                    xs   = xs - dx;
                    ys   = ys + dy;
                    zsum = zsum - atan_step(i);
                end
            end
        end
        acc      = -((zsum + 128) >>> 8) + longint'(cfg_accel_offset);
        gyro_q16 = longint'(pitch_state) * 65536
                 + (longint'(s.gyro_y) + longint'(cfg_gyro_offset)) * 5120;
        blend    = longint'(cfg_alpha) * acc * 65536
                 + (65536 - longint'(cfg_alpha)) * gyro_q16;
        blend    = (blend + 64'sd2147483648) >>> 32;
        if (blend > 32767)
            blend = 32767;
        else if (blend < -32768)
            blend = -32768;
        pitch_state  = blend[15:0];
        mag          = (blend < 0) ? -blend : blend;
        r.tilt_angle = blend[15:0];
        r.over_limit = (mag >= longint'(cfg_tilt_limit));
        return r;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'shFFFF;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'sh7FFF;
        endcase
    endfunction

    function automatic t_in make_sample(input t_gyro_bias bias);
        t_in s;
        case ($urandom_range(9))
            0, 1: begin
                s.accel_x = 16'($urandom);
                s.accel_z = 16'($urandom);
            end
            2: begin
                s.accel_x = 16'(int'($urandom_range(16)) - 8);
                s.accel_z = 16'(int'($urandom_range(16)) - 8);
            end
            3: begin
                if ($urandom_range(1)) begin
                    s.accel_x = '0;
                    s.accel_z = 16'($urandom);
                end else begin
                    s.accel_x = 16'($urandom);
                    s.accel_z = '0;
                end
            end
            4: begin
                s.accel_x = corner_value();
                s.accel_z = corner_value();
            end
            default: begin
                s.accel_x = 16'(int'($urandom_range(24000)) - 12000);
                s.accel_z = 16'(16384 + int'($urandom_range(8192)) - 4096);
                if ($urandom_range(7) == 0)
                    s.accel_z = -s.accel_z;
            end
        endcase
        if ($urandom_range(9) == 0)
            s.gyro_y = corner_value();
        else begin
            case (bias)
                GYRO_CLIMB: s.gyro_y = 16'($urandom_range(32767, 8000));
                GYRO_FALL:  s.gyro_y = 16'(-int'($urandom_range(32768, 8000)));
                default:    s.gyro_y = 16'($urandom);
            endcase
        end
        return s;
    endfunction

    task automatic send_sample(input t_in s, input logic typed, input t_out want);
        t_out p;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            burst_left = $urandom_range(burst_max, 1);
        end
        i_in_data  <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_pitch(s);
        pitch_expected.push_back(typed ? want : p);
        burst_left--;
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pitch_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_reg r, input int value);
        logic [31:0] d, q, mask;
        case (r)
            REG_ACCEL_OFFSET, REG_GYRO_OFFSET: mask = 32'h0000_0FFF;
            REG_ALPHA_WEIGHT:                  mask = 32'h0000_FFFF;
            default:                           mask = 32'h0000_7FFF;
        endcase
        d = $urandom;
        d = (d & ~mask) | (32'(value) & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(r) * 4);
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        q = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if ((q & mask) !== (d & mask)) begin
            $error("register %s read back: expected %h, actual %h", r.name(), d & mask, q & mask);
            mismatches++;
        end
        case (r)
            REG_ACCEL_OFFSET: cfg_accel_offset = d[11:0];
            REG_GYRO_OFFSET:  cfg_gyro_offset  = d[11:0];
            REG_ALPHA_WEIGHT: cfg_alpha        = d[15:0];
            default:          cfg_tilt_limit   = d[14:0];
        endcase
        settings_written++;
    endtask

    task automatic run_phase(input int ao, input int go, input int al, input int tl,
                             input t_gyro_bias bias, input t_sink_mode sink,
                             input int bursts, input int n);
        int k;
        set_reg(REG_ACCEL_OFFSET, ao);
        set_reg(REG_GYRO_OFFSET, go);
        set_reg(REG_ALPHA_WEIGHT, al);
        set_reg(REG_TILT_LIMIT, tl);
        sink_mode = sink;
        burst_max = bursts;
        for (k = 0; k < n; k++)
            send_sample(make_sample(bias), 1'b0, '0);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            case (sink_mode)
                SINK_FREE: begin
                    sink_hold = 1'b0;
                    sink_left = $urandom_range(30, 1);
                end
                SINK_LIGHT: begin
                    sink_hold = ($urandom_range(3) == 0);
                    sink_left = $urandom_range(8, 1);
                end
                default: begin
                    sink_hold = ($urandom_range(4) < 3);
                    sink_left = $urandom_range(40, 1);
                end
            endcase
        end else begin
            sink_left--;
        end
        i_out_stall <= sink_hold;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pitch_expected.size() == 0) begin
                $error("result with nothing pending: tilt_angle %0d over_limit %0b",
                       o_out_data.tilt_angle, o_out_data.over_limit);
                mismatches++;
            end else begin
                want = pitch_expected.pop_front();
                if (o_out_data.tilt_angle !== want.tilt_angle) begin
                    $error("tilt_angle: expected %0d, actual %0d",
                           want.tilt_angle, o_out_data.tilt_angle);
                    mismatches++;
                end
                if (o_out_data.over_limit !== want.over_limit) begin
                    $error("over_limit: expected %0b, actual %0b",
                           want.over_limit, o_out_data.over_limit);
                    mismatches++;
                end
                results_seen++;
            end
        end
    end

    initial begin
        int   k;
        t_row row;
        t_in  s;
        t_out want;
        directed_rows = '{
            '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 16'sd4, 1'b0},
            '{16'sh0000, 16'sh0000, 16'sh8000, 1'b0, 16'sd0, 1'b0},
            '{16'sh0000, 16'sh0001, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
            '{16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'shFFFF, 16'sh0000, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh0000, 16'shFFFF, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh0000, 16'sh8000, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh7FFF, 16'sh0000, 16'shFFFF, 1'b0, 16'sd0, 1'b0},
            '{16'sh8000, 16'sh0000, 16'sh0001, 1'b0, 16'sd0, 1'b0},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 1'b0},
            '{16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh0001, 16'shFFFF, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'shFFFF, 16'shFFFF, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh8000, 16'shFFFF, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
            '{16'sh4000, 16'sh4000, 16'sh0000, 1'b0, 16'sd0, 1'b0},
            '{16'sh0000, 16'sh4000, 16'shFFE2, 1'b0, 16'sd0, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row             = directed_rows[k];
            s.accel_x       = row.ax;
            s.accel_z       = row.az;
            s.gyro_y        = row.gy;
            want.tilt_angle = row.want_angle;
            want.over_limit = row.want_flag;
            send_sample(s, row.typed, want);
        end
        wait_drained();

        run_phase(-2048, 2047, 65535, 0, GYRO_CLIMB, SINK_LIGHT, 8, 150);
        run_phase(2047, -2048, 0, 32767, GYRO_FALL, SINK_HEAVY, 4, 150);
        run_phase(-1280, 1280, 0, 23040, GYRO_CLIMB, SINK_FREE, 200, 150);
        run_phase(1280, -1, 1, 1, GYRO_SPREAD, SINK_LIGHT, 12, 150);
        for (k = 0; k < 7; k++)
            run_phase(int'($urandom_range(4095)), int'($urandom_range(4095)),
                      ($urandom_range(1) ? int'($urandom_range(4000)) : int'($urandom_range(65535))),
                      int'($urandom_range(32767)), t_gyro_bias'($urandom_range(2)),
                      t_sink_mode'($urandom_range(2)), int'($urandom_range(24, 1)), 150);

        $display("run covered %0d samples and %0d results over %0d register writes",
                 samples_sent, results_seen, settings_written);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/tcf_pkg.sv
src/tilt_complementary_filter.sv
src/tcf_checker.sv
sim/tb.sv
